### rtl/core/mlpq_pkg.sv
// Shared types and codes for the multi-level priority queue.
`timescale 1ns / 1ps

package mlpq_pkg;

  // Request operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_LEVELS_IN_USE = 1'b0;
  localparam logic CFG_QUEUE_SIZE    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [3:0] LEVELS_IN_USE_RST = 4'd8;
  localparam logic [4:0] QUEUE_SIZE_RST    = 5'd16;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_PTR,
    CS_FIN
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic resolve;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

### rtl/core/mlpq_ctrl.sv
// Controller state machine of the multi-level priority queue.
`timescale 1ns / 1ps

module mlpq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  mlpq_pkg::dp_status_t   status_i,
  output mlpq_pkg::ctrl_cmd_t    cmd_o
);

  mlpq_pkg::ctrl_state_e state_q, state_d;
  logic                  can_take;
  logic                  accept;

  // A new item is taken when idle, or in the final step once the result leaves.
  assign can_take = (state_q == mlpq_pkg::CS_IDLE) ||
                    ((state_q == mlpq_pkg::CS_FIN) && status_i.out_free);
  assign accept   = in_valid_i && can_take;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlpq_pkg::CS_IDLE: begin
        if (accept) state_d = mlpq_pkg::CS_PTR;
      end
      mlpq_pkg::CS_PTR: begin
        state_d = mlpq_pkg::CS_FIN;
      end
      mlpq_pkg::CS_FIN: begin
        if (status_i.out_free) begin
          state_d = accept ? mlpq_pkg::CS_PTR : mlpq_pkg::CS_IDLE;
        end
      end
      default: state_d = mlpq_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = !can_take;
    cmd_o.accept  = accept;
    cmd_o.resolve = (state_q == mlpq_pkg::CS_PTR);
    cmd_o.finish  = (state_q == mlpq_pkg::CS_FIN) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlpq_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/mlpq_dp.sv
// Datapath of the multi-level priority queue: registers, pointer and entry stores.
`timescale 1ns / 1ps

module mlpq_dp #(
  parameter int LEVELS     = 8,
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [4:0]            cfg_wdata_i,
  input  logic                  op_i,
  input  logic [7:0]            priority_req_i,
  input  logic signed [31:0]    data_in_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [1:0]            status_o,
  output logic signed [31:0]    data_out_o,
  output logic [2:0]            level_out_o,
  input  mlpq_pkg::ctrl_cmd_t   cmd_i,
  output mlpq_pkg::dp_status_t  status_flags_o
);

  localparam int LW    = $clog2(LEVELS);
  localparam int SW    = $clog2(DEPTH);
  localparam int CMP_W = SW + 1;
  localparam int AW    = $clog2(LEVELS * DEPTH);
  localparam logic [AW-1:0] DEPTH_A = AW'(DEPTH);

  // Configuration.
  logic [3:0] levels_in_use_q;
  logic [4:0] queue_size_q;
  logic [7:0] eff_levels;
  logic [CMP_W-1:0] eff_size;

  // Request held while it is worked on.
  logic                  op_q;
  logic [LW-1:0]         lvl_q, lvl_d;
  logic [DATA_WIDTH-1:0] data_q;
  mlpq_pkg::status_e     pre_status_q, pre_status_d;
  logic                  ptr_rd_en;

  // Per-level state.
  logic [LEVELS-1:0] nonempty_q;
  logic [SW-1:0]     head_mem [LEVELS];
  logic [SW-1:0]     tail_mem [LEVELS];
  logic [SW-1:0]     head_rd_q, tail_rd_q;

  // Entry store.
  logic [DATA_WIDTH-1:0] entry_mem [LEVELS * DEPTH];
  logic [DATA_WIDTH-1:0] entry_rd_q;

  // Lowest nonempty level search.
  logic          found;
  logic [LW-1:0] found_lvl;
  logic          ins_range;

  // Resolve step.
  logic              lvl_ne;
  logic [CMP_W-1:0]  tail_nx;
  logic              ins_full;
  logic [SW-1:0]     ins_slot;
  logic              del_last;
  logic [AW-1:0]     row_base;
  mlpq_pkg::status_e res_status_q, res_status_d;

  // Output register.
  logic                  out_valid_q;
  mlpq_pkg::status_e     out_status_q;
  logic signed [31:0]    out_data_q;
  logic [2:0]            out_level_q;
  logic                  del_ok;

  assign eff_levels = (8'(levels_in_use_q) > 8'(LEVELS)) ? 8'(LEVELS) : 8'(levels_in_use_q);
  assign eff_size   = (9'(queue_size_q) > 9'(DEPTH)) ? CMP_W'(DEPTH)
                                                     : CMP_W'(queue_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_in_use_q <= mlpq_pkg::LEVELS_IN_USE_RST;
      queue_size_q    <= mlpq_pkg::QUEUE_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mlpq_pkg::CFG_LEVELS_IN_USE: levels_in_use_q <= cfg_wdata_i[3:0];
        mlpq_pkg::CFG_QUEUE_SIZE:    queue_size_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Priority search over the occupancy flags of the enabled levels.
  always_comb begin
    found     = 1'b0;
    found_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_q[i] && (8'(i) < eff_levels)) begin
        found     = 1'b1;
        found_lvl = LW'(i);
      end
    end
  end

  always_comb begin
    ins_range = (priority_req_i >= eff_levels);
    if (op_i == mlpq_pkg::OP_DELETE) begin
      lvl_d        = found_lvl;
      pre_status_d = found ? mlpq_pkg::ST_OK : mlpq_pkg::ST_EMPTY;
      ptr_rd_en    = found;
    end else begin
      lvl_d        = priority_req_i[LW-1:0];
      pre_status_d = ins_range ? mlpq_pkg::ST_RANGE : mlpq_pkg::ST_OK;
      ptr_rd_en    = !ins_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q         <= op_i;
      lvl_q        <= lvl_d;
      data_q       <= DATA_WIDTH'($unsigned(data_in_i));
      pre_status_q <= pre_status_d;
    end
  end

  // Resolve: decide the slot, update pointers and touch the entry store.
  always_comb begin
    lvl_ne   = nonempty_q[lvl_q];
    tail_nx  = CMP_W'(tail_rd_q) + CMP_W'(1);
    row_base = AW'(lvl_q) * DEPTH_A;
    if (lvl_ne) begin
      ins_full = (tail_nx >= eff_size);
      ins_slot = tail_nx[SW-1:0];
    end else begin
      ins_full = (eff_size == '0);
      ins_slot = '0;
    end
    del_last = (head_rd_q >= tail_rd_q);
    if (pre_status_q != mlpq_pkg::ST_OK) begin
      res_status_d = pre_status_q;
    end else if ((op_q == mlpq_pkg::OP_INSERT) && ins_full) begin
      res_status_d = mlpq_pkg::ST_FULL;
    end else begin
      res_status_d = mlpq_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= '0;
    end else if (cmd_i.resolve && (pre_status_q == mlpq_pkg::ST_OK)) begin
      if (op_q == mlpq_pkg::OP_INSERT) begin
        if (!ins_full) nonempty_q[lvl_q] <= 1'b1;
      end else if (del_last) begin
        nonempty_q[lvl_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && ptr_rd_en) begin
      head_rd_q <= head_mem[lvl_d];
      tail_rd_q <= tail_mem[lvl_d];
    end
    if (cmd_i.resolve && (pre_status_q == mlpq_pkg::ST_OK)) begin
      if (op_q == mlpq_pkg::OP_INSERT) begin
        if (!ins_full) begin
          tail_mem[lvl_q] <= ins_slot;
          if (!lvl_ne) head_mem[lvl_q] <= '0;
        end
      end else if (del_last) begin
        head_mem[lvl_q] <= '0;
        tail_mem[lvl_q] <= '0;
      end else begin
        head_mem[lvl_q] <= head_rd_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve && (pre_status_q == mlpq_pkg::ST_OK)) begin
      if (op_q == mlpq_pkg::OP_INSERT) begin
        if (!ins_full) entry_mem[row_base + AW'(ins_slot)] <= data_q;
      end else begin
        entry_rd_q <= entry_mem[row_base + AW'(head_rd_q)];
      end
    end
    if (cmd_i.resolve) res_status_q <= res_status_d;
  end

  // Output register.
  assign del_ok = (op_q == mlpq_pkg::OP_DELETE) && (res_status_q == mlpq_pkg::ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= res_status_q;
      out_data_q   <= del_ok ? 32'($unsigned(entry_rd_q)) : '0;
      out_level_q  <= del_ok ? 3'(lvl_q) : '0;
    end
  end

  assign status_flags_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_out_o  = out_data_q;
  assign level_out_o = out_level_q;

endmodule

### rtl/core/multi_level_priority_queue_top.sv
// A request item's pointers are read as it is accepted, the entry store is accessed in
// the next cycle during resolution, and the result is registered at completion, which
// waits on a stalled output. A new request item can be taken at the earliest during completion.
// Reset: occupancy flags and controller are cleared at once; the level count returns to
// eight and the slot count to sixteen. The entry and pointer stores need no clearing pass.
`timescale 1ns / 1ps

// Top level of the multi-level priority queue.
//
// Each priority level owns a linear queue of DEPTH slots in a shared entry store.
// An insert item appends a word to the tail of its level, and a delete item removes
// the oldest word from the lowest-numbered level that holds anything. A level's
// slots become free again only when that level has drained completely, at which
// point its head and tail pointers both return to zero.
//
// The work is split between a small controller and a datapath. The controller
// sequences three steps: acceptance, where the target level is chosen and its
// pointers are read; resolution, where the slot is decided and the stores are
// updated; and completion, where the result item is loaded into the output
// register. A new request item is taken during completion, so that the output
// register parts the two channels and the block keeps working while the consumer
// has not yet taken the previous result.
//
// Occupancy of each level lives in flip-flops that reset clears, which is why the
// pointer store and the entry store can hold anything after reset: a level that is
// not marked occupied never has its entries read, and its pointers are read but not used.
module multi_level_priority_queue_top #(
  parameter int LEVELS     = 8,
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [4:0]          cfg_wdata_i,
  // Request channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [7:0]          priority_req_i,
  input  logic signed [31:0]  data_in_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  data_out_o,
  output logic [2:0]          level_out_o
);

  mlpq_pkg::ctrl_cmd_t  cmd;
  mlpq_pkg::dp_status_t dp_status;

  // The controller decides when an item enters and when its result leaves.
  mlpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // The datapath holds the configuration, the stores and the output register.
  mlpq_dp #(
    .LEVELS     (LEVELS),
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (op_i),
    .priority_req_i (priority_req_i),
    .data_in_i      (data_in_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .data_out_o     (data_out_o),
    .level_out_o    (level_out_o),
    .cmd_i          (cmd),
    .status_flags_o (dp_status)
  );

endmodule
